// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BDLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BDLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/bdlp_pkg.sv =====
package bdlp_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [DelayW-1:0] DebounceReset  = 16'd20;
  localparam logic [DelayW-1:0] LongPressReset = 16'd1000;
  localparam logic              ActiveHighReset = 1'b0;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_ACTIVE     = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DelayW-1:0] debounce_time;
    logic [DelayW-1:0] long_press_time;
    logic              active_high;
  } cfg_t;

endpackage

// ===== sv/bdlp_if.sv =====
interface bdlp_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_time;

  modport source(output valid, pin_level, now_time, input ready);
  modport sink(input valid, pin_level, now_time, output ready);
endinterface

interface bdlp_out_if;
  logic valid;
  logic ready;
  logic press_event;
  logic release_event;
  logic long_event;

  modport source(output valid, press_event, release_event, long_event, input ready);
  modport sink(input valid, press_event, release_event, long_event, output ready);
endinterface

// ===== sv/bdlp_cfg.sv =====
module bdlp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdlp_pkg::AddrW-1:0]   paddr,
  input  logic [bdlp_pkg::DataW-1:0]   pwdata,
  output logic [bdlp_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output bdlp_pkg::cfg_t               cfg_o
);
  import bdlp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DebounceReset;
      cfg_q.long_press_time <= LongPressReset;
      cfg_q.active_high     <= ActiveHighReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:   cfg_q.debounce_time   <= pwdata[DelayW-1:0];
        REG_LONG_PRESS: cfg_q.long_press_time <= pwdata[DelayW-1:0];
        REG_ACTIVE:     cfg_q.active_high     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE:   prdata = {{(DataW-DelayW){1'b0}}, cfg_q.debounce_time};
      REG_LONG_PRESS: prdata = {{(DataW-DelayW){1'b0}}, cfg_q.long_press_time};
      REG_ACTIVE:     prdata = {{(DataW-1){1'b0}}, cfg_q.active_high};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/bdlp_core.sv =====
`include "assert_macros.svh"

module bdlp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bdlp_pkg::cfg_t cfg_i,
  bdlp_in_if.sink        in_ch,
  bdlp_out_if.source     out_ch
);
  import bdlp_pkg::*;

  // input register
  logic              in_valid_q, in_valid_d;
  logic              in_pin_q;
  logic [TimeW-1:0]  in_time_q;

  // button state
  logic              prev_level_q, prev_level_d;
  logic [TimeW-1:0]  change_time_q, change_time_d;
  logic              stable_level_q, stable_level_d;
  logic [TimeW-1:0]  press_time_q, press_time_d;
  logic              long_done_q, long_done_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              press_q, release_q, long_q;

  logic              in_xfer, adv;
  logic              level, stab_chg, press_d, release_d, long_d;
  logic [TimeW-1:0]  held_time, since_press;

  assign adv     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_valid_q || adv;

  always_comb begin
    level        = (in_pin_q == cfg_i.active_high);
    prev_level_d = level;
    // a level change restarts the debounce timer
    change_time_d = (level != prev_level_q) ? in_time_q : change_time_q;
    held_time     = in_time_q - change_time_d;
    stab_chg      = (held_time >= {{(TimeW-DelayW){1'b0}}, cfg_i.debounce_time})
                    && (stable_level_q != level);
    press_d        = stab_chg && level;
    release_d      = stab_chg && !level;
    stable_level_d = stab_chg ? level : stable_level_q;
    press_time_d   = press_d ? in_time_q : press_time_q;
    since_press    = in_time_q - press_time_d;
    long_d = stable_level_d && !(long_done_q && !press_d)
             && (since_press >= {{(TimeW-DelayW){1'b0}}, cfg_i.long_press_time});
    long_done_d = long_d || (long_done_q && !press_d);
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      prev_level_q   <= 1'b0;
      change_time_q  <= '0;
      stable_level_q <= 1'b0;
      press_time_q   <= '0;
      long_done_q    <= 1'b0;
      press_q        <= 1'b0;
      release_q      <= 1'b0;
      long_q         <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        prev_level_q   <= prev_level_d;
        change_time_q  <= change_time_d;
        stable_level_q <= stable_level_d;
        press_time_q   <= press_time_d;
        long_done_q    <= long_done_d;
        press_q        <= press_d;
        release_q      <= release_d;
        long_q         <= long_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_pin_q  <= in_ch.pin_level;
      in_time_q <= in_ch.now_time;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.press_event   = press_q;
  assign out_ch.release_event = release_q;
  assign out_ch.long_event    = long_q;

  `BDLP_ASSERT_ALWAYS(a_no_press_and_release, !(press_q && release_q), "press and release together")
  `BDLP_ASSERT(a_release_state, out_valid_q && release_q |-> !stable_level_q, "release but pressed")
  `BDLP_ASSERT(a_long_state, out_valid_q && long_q |-> long_done_q && stable_level_q, "long state")
  `BDLP_ASSERT(a_adv_result, adv |=> out_valid_q, "processed item lost its result")
  `BDLP_ASSERT(a_long_once, adv && long_done_q && !press_d |-> !long_d, "long press repeated")

endmodule

// ===== sv/button_debounce_long_press_top.sv =====
// an item passes the input register and then the result register before its result can be transferred
// throughput: one item per cycle while results are taken, set by the single-pass update of the button state
// the result register lets the next item enter while a result waits to be taken
// reset (rst_ni low, asynchronous) clears all state as though initialized at time 0
// and loads the register defaults: debounce 20 ms, long press 1000 ms, active low
module button_debounce_long_press_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bdlp_in_if.sink                     in_ch,
  bdlp_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdlp_pkg::AddrW-1:0]  paddr,
  input  logic [bdlp_pkg::DataW-1:0]  pwdata,
  output logic [bdlp_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import bdlp_pkg::*;

  cfg_t cfg;

  bdlp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/bdlp_checker.sv =====
module bdlp_checker
  import bdlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bdlp_in_if                in_ch,
  bdlp_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output int unsigned       fail_cnt_o,
  output int unsigned       waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic long_event;
  } btn_evt_t;

  cfg_t              cfg;
  logic              last_level;
  logic              stable_level;
  logic              long_done;
  logic [TimeW-1:0]  change_stamp;
  logic [TimeW-1:0]  press_stamp;
  btn_evt_t          pending_events[$];
  btn_evt_t          want;
  int unsigned       fails;

  // advances the button state by one pin sample and returns its events
  function automatic btn_evt_t button_events(input logic pin, input logic [TimeW-1:0] ms);
    btn_evt_t          evt;
    logic              pressed;
    logic [TimeW-1:0]  held;
    logic [TimeW-1:0]  held_down;
    evt = '0;
    pressed = (pin == cfg.active_high);
    if (pressed != last_level) begin
      last_level = pressed;
      change_stamp = ms;
    end
    held = ms - change_stamp;
    if (held >= {16'd0, cfg.debounce_time} && stable_level != pressed) begin
      stable_level = pressed;
      if (pressed) begin
        press_stamp = ms;
        long_done = 1'b0;
        evt.press_event = 1'b1;
      end else begin
        evt.release_event = 1'b1;
      end
    end
    held_down = ms - press_stamp;
    if (stable_level && !long_done && held_down >= {16'd0, cfg.long_press_time}) begin
      long_done = 1'b1;
      evt.long_event = 1'b1;
    end
    return evt;
  endfunction

  function automatic int unsigned field_mismatch(input string field, input logic exp_bit,
                                                 input logic got_bit);
    if (got_bit !== exp_bit) begin
      $error("%s: expected %0b, got %0b", field, exp_bit, got_bit);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.debounce_time   = DebounceReset;
      cfg.long_press_time = LongPressReset;
      cfg.active_high     = ActiveHighReset;
      last_level   = 1'b0;
      stable_level = 1'b0;
      long_done    = 1'b0;
      change_stamp = '0;
      press_stamp  = '0;
      pending_events.delete();
      fails = 0;
      fail_cnt_o <= 0;
      waiting_o  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          REG_DEBOUNCE:   cfg.debounce_time   = pwdata[DelayW-1:0];
          REG_LONG_PRESS: cfg.long_press_time = pwdata[DelayW-1:0];
          REG_ACTIVE:     cfg.active_high     = pwdata[0];
          default: ;
        endcase
      end
      // a result can never belong to an item taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (pending_events.size() == 0) begin
          $error("result transfer with no expected result");
          fails++;
        end else begin
          want = pending_events.pop_front();
          fails += field_mismatch("press_event", want.press_event, out_ch.press_event);
          fails += field_mismatch("release_event", want.release_event, out_ch.release_event);
          fails += field_mismatch("long_event", want.long_event, out_ch.long_event);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_events.push_back(button_events(in_ch.pin_level, in_ch.now_time));
      end
      fail_cnt_o <= fails;
      waiting_o  <= pending_events.size();
    end
  end

endmodule

// ===== tb/tb_button_debounce_long_press_top.sv =====
module tb_button_debounce_long_press_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bdlp_pkg::*;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned Latency       = 2;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned ItemsPerPhase = 125;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  int unsigned       fail_cnt;
  int unsigned       waiting;
  int unsigned       quiet;
  bit                calm;
  cfg_t              drive_cfg;
  logic [TimeW-1:0]  stamp;

  bdlp_in_if  in_ch();
  bdlp_out_if out_ch();

  button_debounce_long_press_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bdlp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_cnt_o (fail_cnt),
    .waiting_o  (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  task automatic push_sample(input logic pin, input logic [TimeW-1:0] ms);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= pin;
    in_ch.now_time  <= ms;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (waiting == 0);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk that the registers must drop
  task automatic load_config(input cfg_t c);
    drain();
    apb_write(REG_DEBOUNCE, {16'($urandom()), c.debounce_time});
    apb_write(REG_LONG_PRESS, {16'($urandom()), c.long_press_time});
    apb_write(REG_ACTIVE, {31'($urandom()), c.active_high});
    drive_cfg = c;
  endtask

  // held presses and releases with bounce, boundary steps and timestamp jumps
  task automatic press_sequences(input int unsigned count);
    logic         target;
    logic         bounce;
    int unsigned  scale;
    int unsigned  pick;
    target = 1'b0;
    scale = (int'(drive_cfg.debounce_time) + int'(drive_cfg.long_press_time)) / 3 + 2;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) target = ~target;
      bounce = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 13) stamp += $urandom_range(0, scale);
      else if (pick < 15) stamp += 0;
      else if (pick < 17) stamp += drive_cfg.debounce_time;
      else if (pick < 18) stamp += drive_cfg.long_press_time;
      else stamp = $urandom();
      push_sample((target ~^ drive_cfg.active_high) ^ bounce, stamp);
    end
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && stall == 0 && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("tb_button_debounce_long_press_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    in_ch.now_time  = '0;
    quiet           = 0;
    calm            = 1'b0;
    drive_cfg       = '{debounce_time: DebounceReset, long_press_time: LongPressReset,
                        active_high: ActiveHighReset};
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: 20 ms debounce, 1000 ms long press, pin low is pressed
    push_sample(1'b1, 32'd0);
    push_sample(1'b0, 32'd5);
    push_sample(1'b0, 32'd24);
    push_sample(1'b0, 32'd25);
    push_sample(1'b0, 32'd1024);
    push_sample(1'b0, 32'd1025);
    push_sample(1'b0, 32'd1030);
    push_sample(1'b1, 32'd1031);
    push_sample(1'b1, 32'd1051);
    // still released long after, so no long press
    push_sample(1'b1, 32'd5000);
    // bouncing contact restarts the debounce timer
    push_sample(1'b0, 32'd6000);
    push_sample(1'b1, 32'd6005);
    push_sample(1'b0, 32'd6010);
    push_sample(1'b0, 32'd6029);
    push_sample(1'b0, 32'd6030);
    // timestamp wrapping through zero
    push_sample(1'b1, 32'hFFFF_FFF0);
    push_sample(1'b1, 32'h0000_0003);
    push_sample(1'b1, 32'h0000_0004);
    // timestamp going backwards
    push_sample(1'b0, 32'h0000_0100);
    push_sample(1'b0, 32'h0000_0050);
    push_sample(1'b0, 32'h0000_0437);
    push_sample(1'b0, 32'h0000_0438);
    push_sample(1'b1, 32'hFFFF_FFFF);
    push_sample(1'b1, 32'h8000_0000);
    stamp = 32'h8000_0000;

    load_config('{debounce_time: 16'd0, long_press_time: 16'd0, active_high: 1'b1});
    press_sequences(ItemsPerPhase);
    load_config('{debounce_time: 16'hFFFF, long_press_time: 16'hFFFF, active_high: 1'b0});
    press_sequences(ItemsPerPhase);
    drain();
    apb_write(REG_NONE, $urandom());
    load_config('{debounce_time: 16'd7, long_press_time: 16'd40, active_high: 1'b1});
    press_sequences(ItemsPerPhase);
    load_config('{debounce_time: 16'd1, long_press_time: 16'hFFFF, active_high: 1'b0});
    press_sequences(ItemsPerPhase);
    load_config('{debounce_time: 16'd20, long_press_time: 16'd300, active_high: 1'b1});
    calm = 1'b1;
    press_sequences(ItemsPerPhase);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_button_debounce_long_press_top: PASS");
    end else begin
      $display("tb_button_debounce_long_press_top: FAIL");
    end
    $finish;
  end

endmodule
